// ===== design/sod_pkg.sv =====
// Package for the sigma outlier detector: operation codes, result type and
// controller command/status structs. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sod_pkg;
  localparam logic [1:0] OP_CLEAR   = 2'd0;
  localparam logic [1:0] OP_LOAD    = 2'd1;
  localparam logic [1:0] OP_COMPUTE = 2'd2;
  localparam logic [1:0] OP_SAMPLE  = 2'd3;

  typedef struct packed {
    logic        store_full;
    logic [15:0] low_day;
    logic [15:0] low_value;
    logic        low_found;
    logic [15:0] high_day;
    logic [15:0] high_value;
    logic        high_found;
    logic        stats_ready;
    logic [15:0] deviation;
    logic [15:0] mean_temp;
  } result_t;

  // controller -> datapath
  typedef struct packed {
    logic take;      // latch input item, run clear, load and sample ops
    logic sum_clr;   // start of pass one
    logic sum_acc;   // add store entry idx-1 from the registered read
    logic div_start; // start a divide
    logic div_sel;   // 0: sum/count, 1: sq/count
    logic mean_set;  // take mean from quotient
    logic sq_acc;    // add squared difference
    logic root_start;
    logic stats_set; // write deviation and ready
    logic empty_set; // compute on empty store
    logic out_load;  // capture result beat
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic div_done;
    logic root_done;
    logic empty;
  } status_t;
endpackage
`default_nettype wire

// ===== design/sigma_outlier_detector.sv =====
// Top level of the sigma outlier detector: stream ports, sigma register,
// controller and datapath. Uses sod_pkg, sod_ctrl, sod_datapath.
`timescale 1ns / 1ps
`default_nettype none
// Loads daily averages into a MAX_DAYS-entry store, computes mean and
// population deviation on a compute beat, and flags hourly samples farther
// than sigma_multiple deviations from the mean, tracking the largest and
// smallest flagged sample. Every input beat yields one result beat. Clear,
// load and sample beats execute on accept, then their result is captured,
// as is a compute on an empty store. A compute beat walks the store twice
// through the registered store read, starts each divide from its own state,
// and runs two serial divides of 34+clog2(MAX_DAYS+1) steps each and a root
// of about half that many steps before its result is captured. The next
// beat is accepted only once the previous result beat has been taken or is
// taken in the same cycle.
module sigma_outlier_detector #(
  parameter int MAX_DAYS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [3:0]  cfg_wdata,    // sigma_multiple
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,     // temperature[15:0], day_code[31:16]
  input  wire logic [1:0]  in_tuser,     // operation[1:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [103:0]     out_tdata     // mean_temp, deviation, stats_ready,
                                         // high_found, high_value, high_day,
                                         // low_found, low_value, low_day,
                                         // store_full, zero fill
);
  import sod_pkg::*;
  localparam int CW = $clog2(MAX_DAYS + 1);

  logic [3:0] sigma_r;
  cmd_t cmd;
  status_t sts;
  result_t res;
  logic [CW-1:0] idx;
  logic [1:0] op;
  logic [CW-1:0] count;

  // hold sigma; the user must write it only while idle, the block does not enforce this
  always_ff @(posedge clk) begin
    if (!rst_n) sigma_r <= 4'd3;
    else if (cfg_we) sigma_r <= cfg_wdata;
  end

  assign op = in_tuser;

  // controller needs the fill count; rebuild it from load beats here
  logic [CW-1:0] count_r;
  always_ff @(posedge clk) begin
    if (!rst_n) count_r <= '0;
    else if (cmd.take) begin
      if (op == OP_CLEAR) count_r <= '0;
      else if (op == OP_LOAD && count_r < CW'(MAX_DAYS)) count_r <= count_r + 1'b1;
    end
  end
  assign count = count_r;

  sod_ctrl #(.MAX_DAYS(MAX_DAYS)) u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready, .op, .out_tvalid, .out_tready,
    .sts, .cmd, .idx, .count
  );

  sod_datapath #(.MAX_DAYS(MAX_DAYS)) u_dp (
    .clk, .rst_n, .cmd, .sts, .idx, .op,
    .temp(in_tdata[15:0]), .day(in_tdata[31:16]), .sigma(sigma_r), .res
  );

  assign out_tdata = {
    4'd0, res.store_full, res.low_day, res.low_value, res.low_found,
    res.high_day, res.high_value, res.high_found, res.stats_ready,
    res.deviation, res.mean_temp
  };
endmodule
`default_nettype wire

// ===== design/sod_datapath.sv =====
// Datapath of the sigma outlier detector: day store, accumulators, serial
// divider and root unit, trackers and result register. Uses sod_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sod_datapath #(
  parameter int MAX_DAYS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire sod_pkg::cmd_t      cmd,
  output sod_pkg::status_t        sts,
  input  wire logic [$clog2(MAX_DAYS+1)-1:0] idx,
  input  wire logic [1:0]         op,
  input  wire logic signed [15:0] temp,
  input  wire logic [15:0]        day,
  input  wire logic [3:0]         sigma,
  output sod_pkg::result_t        res
);
  import sod_pkg::*;
  localparam int CW = $clog2(MAX_DAYS + 1);
  localparam int AW = (MAX_DAYS > 1) ? $clog2(MAX_DAYS) : 1;
  localparam int SW = 17 + CW;   // signed sum width
  localparam int QW = 34 + CW;   // squared sum width
  localparam int DW = QW;        // divider width (unsigned)

  logic signed [15:0] store_mem [MAX_DAYS];
  logic signed [15:0] rd_r;
  logic [CW-1:0] count_r;
  logic signed [SW-1:0] sum_r;
  logic [QW-1:0] sq_r;
  logic signed [15:0] mean_r;
  logic [15:0] dev_r;
  logic ready_r, hs_r, ls_r, full_r;
  logic signed [15:0] ht_r, lt_r;
  logic [15:0] hd_r, ld_r;
  logic [AW-1:0] ridx;

  assign ridx = idx[AW-1:0];
  assign sts.empty = (count_r == '0);

  // store write on load, registered read for the passes
  always_ff @(posedge clk) begin
    if (cmd.take && op == OP_LOAD && count_r < CW'(MAX_DAYS))
      store_mem[count_r[AW-1:0]] <= temp;
    rd_r <= store_mem[ridx];
  end

  // serial restoring divider: magnitude / count, sign fixed after
  logic [DW-1:0] dq_r, drem_r;
  logic [$clog2(DW+1)-1:0] dcnt_r;
  logic dbusy_r, dneg_r, ddone_r;
  logic [DW-1:0] dnum;
  logic [DW:0] dtrial;
  always_comb begin
    if (!cmd.div_sel)
      dnum = sum_r[SW-1] ? DW'(-sum_r) : DW'(sum_r);
    else
      dnum = sq_r;
    dtrial = {drem_r, dq_r[DW-1]} - {{(DW+1-CW){1'b0}}, count_r};
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dbusy_r <= 1'b0;
      ddone_r <= 1'b0;
    end else begin
      ddone_r <= 1'b0;
      if (cmd.div_start) begin
        dbusy_r <= 1'b1;
        dq_r    <= dnum;
        drem_r  <= '0;
        dcnt_r  <= '0;
        dneg_r  <= !cmd.div_sel && sum_r[SW-1];
      end else if (dbusy_r) begin
        if (!dtrial[DW]) begin
          drem_r <= dtrial[DW-1:0];
          dq_r   <= {dq_r[DW-2:0], 1'b1};
        end else begin
          drem_r <= {drem_r[DW-2:0], dq_r[DW-1]};
          dq_r   <= {dq_r[DW-2:0], 1'b0};
        end
        dcnt_r <= dcnt_r + 1'b1;
        if (dcnt_r == ($clog2(DW+1))'(DW - 1)) begin
          dbusy_r <= 1'b0;
          ddone_r <= 1'b1;
        end
      end
    end
  end
  assign sts.div_done = ddone_r;

  // bit-pair root, two bits of radicand per cycle
  localparam int RW = QW + (QW % 2);
  logic [RW-1:0] rv_r, rres_r, rbit_r;
  logic rbusy_r, rdone_r;
  logic [RW:0] rtry;
  assign rtry = {1'b0, rv_r} - {1'b0, rres_r | rbit_r};
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rbusy_r <= 1'b0;
      rdone_r <= 1'b0;
    end else begin
      rdone_r <= 1'b0;
      if (cmd.root_start) begin
        rbusy_r <= 1'b1;
        rv_r    <= RW'(dq_r);
        rres_r  <= '0;
        rbit_r  <= RW'(1) << (RW - 2);
      end else if (rbusy_r) begin
        if (!rtry[RW]) begin
          rv_r   <= rtry[RW-1:0];
          rres_r <= (rres_r >> 1) | rbit_r;
        end else begin
          rres_r <= rres_r >> 1;
        end
        rbit_r <= rbit_r >> 2;
        if (rbit_r[0]) begin
          rbusy_r <= 1'b0;
          rdone_r <= 1'b1;
        end
      end
    end
  end
  assign sts.root_done = rdone_r;

  // sample check
  logic signed [17:0] diff;
  logic [16:0] mag;
  logic [19:0] lim;
  logic outl;
  assign diff = 18'(temp) - 18'(mean_r);
  assign mag  = diff[17] ? 17'(-diff) : diff[16:0];
  assign lim  = 20'(sigma) * 20'(dev_r);
  assign outl = ready_r && (20'(mag) > lim);

  logic signed [16:0] sdiff;
  logic [33:0] sqd;
  assign sdiff = 17'(rd_r) - 17'(mean_r);
  assign sqd = 34'($signed(sdiff) * $signed(sdiff));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0; mean_r <= '0; dev_r <= '0; ready_r <= 1'b0;
      hs_r <= 1'b0; ht_r <= '0; hd_r <= '0;
      ls_r <= 1'b0; lt_r <= '0; ld_r <= '0;
      full_r <= 1'b0;
    end else begin
      if (cmd.take) begin
        // hold the dropped-load flag for this beat's result
        full_r <= (op == OP_LOAD) && (count_r == CW'(MAX_DAYS));
        unique case (op)
          OP_CLEAR: begin
            count_r <= '0; mean_r <= '0; dev_r <= '0; ready_r <= 1'b0;
            hs_r <= 1'b0; ht_r <= '0; hd_r <= '0;
            ls_r <= 1'b0; lt_r <= '0; ld_r <= '0;
          end
          OP_LOAD:
            if (count_r < CW'(MAX_DAYS)) count_r <= count_r + 1'b1;
          OP_COMPUTE: begin
            hs_r <= 1'b0; ht_r <= '0; hd_r <= '0;
            ls_r <= 1'b0; lt_r <= '0; ld_r <= '0;
          end
          OP_SAMPLE:
            if (outl) begin
              if (!hs_r || temp > ht_r) begin
                hs_r <= 1'b1; ht_r <= temp; hd_r <= day;
              end
              if (!ls_r || temp < lt_r) begin
                ls_r <= 1'b1; lt_r <= temp; ld_r <= day;
              end
            end
          default: ;
        endcase
      end
      if (cmd.mean_set)
        mean_r <= dneg_r ? 16'(-dq_r) : dq_r[15:0];
      if (cmd.empty_set) begin
        mean_r <= '0; dev_r <= '0; ready_r <= 1'b0;
      end
      if (cmd.stats_set) begin
        dev_r   <= (rres_r > RW'(16'hFFFF)) ? 16'hFFFF : rres_r[15:0];
        ready_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sum_clr) begin
      sum_r <= '0;
      sq_r  <= '0;
    end
    if (cmd.sum_acc) sum_r <= sum_r + SW'(rd_r);
    if (cmd.sq_acc)  sq_r  <= sq_r + QW'(sqd);
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      res.mean_temp   <= mean_r;
      res.deviation   <= dev_r;
      res.stats_ready <= ready_r;
      res.high_found  <= hs_r;
      res.high_value  <= ht_r;
      res.high_day    <= hd_r;
      res.low_found   <= ls_r;
      res.low_value   <= lt_r;
      res.low_day     <= ld_r;
      res.store_full  <= full_r;
    end
  end
endmodule
`default_nettype wire

// ===== design/sod_ctrl.sv =====
// Controller of the sigma outlier detector: handshakes and the compute
// sequence over the store. Uses sod_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sod_ctrl #(
  parameter int MAX_DAYS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [1:0]        op,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  input  wire sod_pkg::status_t  sts,
  output sod_pkg::cmd_t          cmd,
  output logic [$clog2(MAX_DAYS+1)-1:0] idx,
  input  wire logic [$clog2(MAX_DAYS+1)-1:0] count
);
  import sod_pkg::*;
  localparam int CW = $clog2(MAX_DAYS + 1);
  localparam logic [3:0] S_IDLE = 4'd0, S_SUM = 4'd1, S_DIV1 = 4'd2,
    S_SQ = 4'd3, S_DIV2 = 4'd4, S_ROOT = 4'd5, S_FIN = 4'd6, S_OUT = 4'd7,
    S_SUMW = 4'd8, S_SQW = 4'd9, S_DST1 = 4'd10, S_DST2 = 4'd11;

  logic [3:0] state_r, state_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic ov_r, ov_nxt;
  logic acc;

  assign in_tready  = (state_r == S_IDLE) && (!ov_r || out_tready);
  assign out_tvalid = ov_r;
  assign acc = in_tvalid && in_tready;
  assign idx = idx_r;

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    ov_nxt    = ov_r && !out_tready;
    cmd       = '0;
    unique case (state_r)
      S_IDLE:
        if (acc) begin
          cmd.take = 1'b1;
          if (op == OP_COMPUTE) begin
            if (sts.empty) begin
              cmd.empty_set = 1'b1;
              state_nxt = S_OUT;
            end else begin
              cmd.sum_clr = 1'b1;
              idx_nxt = '0;
              state_nxt = S_SUMW;
            end
          end else begin
            state_nxt = S_OUT;
          end
        end
      S_SUMW: begin
        idx_nxt = idx_r + 1'b1;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        // read data for entry idx-1 is valid
        cmd.sum_acc = 1'b1;
        if (idx_r == count) begin
          state_nxt = S_DST1;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_DST1: begin
        // sum is complete; start the mean divide
        cmd.div_start = 1'b1;
        state_nxt = S_DIV1;
      end
      S_DIV1:
        if (sts.div_done) begin
          cmd.mean_set = 1'b1;
          idx_nxt = '0;
          state_nxt = S_SQW;
        end
      S_SQW: begin
        idx_nxt = idx_r + 1'b1;
        state_nxt = S_SQ;
      end
      S_SQ: begin
        cmd.sq_acc = 1'b1;
        if (idx_r == count) begin
          state_nxt = S_DST2;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_DST2: begin
        cmd.div_start = 1'b1;
        cmd.div_sel = 1'b1;
        state_nxt = S_DIV2;
      end
      S_DIV2: begin
        cmd.div_sel = 1'b1;
        if (sts.div_done) begin
          cmd.root_start = 1'b1;
          state_nxt = S_ROOT;
        end
      end
      S_ROOT:
        if (sts.root_done) begin
          cmd.stats_set = 1'b1;
          state_nxt = S_FIN;
        end
      S_FIN: state_nxt = S_OUT;
      S_OUT:
        if (!ov_r || out_tready) begin
          cmd.out_load = 1'b1;
          ov_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      ov_r    <= ov_nxt;
    end
  end
endmodule
`default_nettype wire
